// File: rtl/fspm_pkg.sv
`default_nettype none
package fspm_pkg;

    // Matcher phase
    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_PRE  = 2'd1,
        PH_WAIT = 2'd2,
        PH_POST = 2'd3
    } t_phase;

    // How a pattern element checks the operands
    typedef enum logic [2:0] {
        KD_NONE  = 3'd0,
        KD_ONE   = 3'd1,
        KD_TWO   = 3'd2,
        KD_IMM   = 3'd3,
        KD_HI    = 3'd4,
        KD_HIREG = 3'd5
    } t_kind;

    typedef struct packed {
        logic [3:0] mn;
        t_kind      kind;
        logic [4:0] r0;
        logic [4:0] r1;
    } t_elem;

    localparam int N_PRE  = 9;
    localparam int N_POST = 13;
    localparam int POST_DEPTH = 4;

    // Mnemonic classes
    localparam logic [3:0] MN_OTHER = 4'd0;
    localparam logic [3:0] MN_NOP   = 4'd1;
    localparam logic [3:0] MN_LEAVE = 4'd2;
    localparam logic [3:0] MN_RET   = 4'd3;
    localparam logic [3:0] MN_XOR   = 4'd4;
    localparam logic [3:0] MN_POP   = 4'd5;
    localparam logic [3:0] MN_PUSH  = 4'd6;
    localparam logic [3:0] MN_MOV   = 4'd7;
    localparam logic [3:0] MN_SUB   = 4'd8;
    localparam logic [3:0] MN_ENDBR = 4'd9;

    // Operand kinds
    localparam logic [1:0] OP_UNUSED = 2'd0;
    localparam logic [1:0] OP_REG    = 2'd1;
    localparam logic [1:0] OP_IMM    = 2'd2;

    // Register codes
    localparam logic [4:0] REG_NONE = 5'd0;
    localparam logic [4:0] REG_RAX  = 5'd1;
    localparam logic [4:0] REG_RBX  = 5'd4;
    localparam logic [4:0] REG_RSP  = 5'd5;
    localparam logic [4:0] REG_RBP  = 5'd6;
    localparam logic [4:0] REG_RDI  = 5'd8;
    localparam logic [4:0] REG_R12  = 5'd13;
    localparam logic [4:0] REG_R13  = 5'd14;
    localparam logic [4:0] REG_R14  = 5'd15;
    localparam logic [4:0] REG_R15  = 5'd16;
    localparam logic [4:0] REG_EAX  = 5'd17;

    // Pattern elements
    localparam t_elem EL_NULL      = '{MN_OTHER, KD_NONE, REG_NONE, REG_NONE};
    localparam t_elem EL_NOP       = '{MN_NOP, KD_NONE, REG_NONE, REG_NONE};
    localparam t_elem EL_LEAVE     = '{MN_LEAVE, KD_NONE, REG_NONE, REG_NONE};
    localparam t_elem EL_RET       = '{MN_RET, KD_NONE, REG_NONE, REG_NONE};
    localparam t_elem EL_XOR_EAX   = '{MN_XOR, KD_TWO, REG_EAX, REG_EAX};
    localparam t_elem EL_POP_RBX   = '{MN_POP, KD_ONE, REG_RBX, REG_NONE};
    localparam t_elem EL_POP_RBP   = '{MN_POP, KD_ONE, REG_RBP, REG_NONE};
    localparam t_elem EL_POP_R12   = '{MN_POP, KD_ONE, REG_R12, REG_NONE};
    localparam t_elem EL_POP_R13   = '{MN_POP, KD_ONE, REG_R13, REG_NONE};
    localparam t_elem EL_POP_R14   = '{MN_POP, KD_ONE, REG_R14, REG_NONE};
    localparam t_elem EL_POP_R15   = '{MN_POP, KD_ONE, REG_R15, REG_NONE};
    localparam t_elem EL_ENDBR     = '{MN_ENDBR, KD_NONE, REG_NONE, REG_NONE};
    localparam t_elem EL_PUSH_RBX  = '{MN_PUSH, KD_ONE, REG_RBX, REG_NONE};
    localparam t_elem EL_PUSH_RBP  = '{MN_PUSH, KD_ONE, REG_RBP, REG_NONE};
    localparam t_elem EL_PUSH_R12  = '{MN_PUSH, KD_ONE, REG_R12, REG_NONE};
    localparam t_elem EL_PUSH_R13  = '{MN_PUSH, KD_ONE, REG_R13, REG_NONE};
    localparam t_elem EL_PUSH_R14  = '{MN_PUSH, KD_ONE, REG_R14, REG_NONE};
    localparam t_elem EL_PUSH_R15  = '{MN_PUSH, KD_ONE, REG_R15, REG_NONE};
    localparam t_elem EL_PUSH_HI   = '{MN_PUSH, KD_HI, REG_NONE, REG_NONE};
    localparam t_elem EL_MOV_HIREG = '{MN_MOV, KD_HIREG, REG_NONE, REG_NONE};
    localparam t_elem EL_MOV_BP_SP = '{MN_MOV, KD_TWO, REG_RBP, REG_RSP};
    localparam t_elem EL_MOV_BP_DI = '{MN_MOV, KD_TWO, REG_RBP, REG_RDI};
    localparam t_elem EL_MOV_BX_DI = '{MN_MOV, KD_TWO, REG_RBX, REG_RDI};
    localparam t_elem EL_SUB_SP    = '{MN_SUB, KD_IMM, REG_RSP, REG_NONE};

    // End-of-function prepatterns
    localparam logic [1:0] PRE_LEN [N_PRE] = '{
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
    };
    localparam t_elem PRE_E0 [N_PRE] = '{
        EL_NOP, EL_LEAVE, EL_XOR_EAX, EL_POP_RBX, EL_POP_RBP,
        EL_POP_R12, EL_POP_R13, EL_POP_R14, EL_POP_R15
    };
    localparam t_elem PRE_E1 [N_PRE] = '{
        EL_NULL, EL_RET, EL_RET, EL_RET, EL_RET, EL_RET, EL_RET, EL_RET, EL_RET
    };

    // Prologue postpatterns
    localparam logic [2:0] POST_LEN [N_POST] = '{
        3'd1, 3'd3, 3'd4, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2
    };
    localparam t_elem POST_E [N_POST][POST_DEPTH] = '{
        '{EL_ENDBR,    EL_NULL,      EL_NULL,      EL_NULL},
        '{EL_PUSH_R12, EL_PUSH_RBP,  EL_MOV_HIREG, EL_NULL},
        '{EL_PUSH_R12, EL_PUSH_RBP,  EL_PUSH_RBX,  EL_MOV_HIREG},
        '{EL_PUSH_R15, EL_PUSH_R14,  EL_PUSH_R13,  EL_NULL},
        '{EL_PUSH_R14, EL_PUSH_R13,  EL_NULL,      EL_NULL},
        '{EL_PUSH_R13, EL_PUSH_R12,  EL_NULL,      EL_NULL},
        '{EL_PUSH_HI,  EL_MOV_HIREG, EL_PUSH_RBP,  EL_NULL},
        '{EL_PUSH_HI,  EL_PUSH_HI,   EL_MOV_HIREG, EL_NULL},
        '{EL_PUSH_RBP, EL_MOV_BP_SP, EL_SUB_SP,    EL_NULL},
        '{EL_PUSH_RBP, EL_MOV_BP_SP, EL_PUSH_RBX,  EL_NULL},
        '{EL_PUSH_RBP, EL_MOV_BP_DI, EL_PUSH_RBX,  EL_NULL},
        '{EL_PUSH_RBX, EL_MOV_BX_DI, EL_NULL,      EL_NULL},
        '{EL_PUSH_RBX, EL_SUB_SP,    EL_NULL,      EL_NULL}
    };

    // Compare one decoded instruction against one pattern element
    function automatic logic elem_match(
        input t_elem      e,
        input logic [3:0] mn,
        input logic [1:0] k0,
        input logic [4:0] g0,
        input logic [1:0] k1,
        input logic [4:0] g1
    );
        logic hit;
        logic hi0;
        logic gp1;
        hi0 = (g0 >= REG_R12) && (g0 <= REG_R15);
        gp1 = (g1 >= REG_RAX) && (g1 <= REG_R15);
        unique case (e.kind)
            KD_ONE:   hit = (k0 == OP_REG) && (k1 == OP_UNUSED) && (g0 == e.r0);
            KD_TWO:   hit = (k0 == OP_REG) && (k1 == OP_REG) && (g0 == e.r0)
                            && (g1 == e.r1);
            KD_IMM:   hit = (k0 == OP_REG) && (k1 == OP_IMM) && (g0 == e.r0);
            KD_HI:    hit = (k0 == OP_REG) && hi0;
            KD_HIREG: hit = (k0 == OP_REG) && (k1 == OP_REG) && hi0 && gp1;
            default:  hit = 1'b1;
        endcase
        return (mn == e.mn) && hit;
    endfunction

endpackage
`default_nettype wire

// File: rtl/function_start_pattern_matcher_unit.sv
// Function start pattern matcher.
// Input channel (i_valid / o_stall): one decoded x86-64 instruction per
// request, with its decode status, address, mnemonic class and operands.
// A request is taken at a clock edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one function start address per
// request that completes a prologue after an end-of-function pattern.
// Most requests produce no result.
// Throughput: one request per cycle while o_stall is low; the pattern
// tables are compared in parallel and the matcher state updates in the same cycle.
// A result is registered into the output entry when the request that
// completes it is taken, or into the skid entry while the output is held.
// The result side is a two-entry register pair (output plus skid): while
// the receiver stalls, one more result can land in the skid entry, and
// o_stall rises only while the skid entry is occupied.
// Reset (i_rst_n low, synchronous) returns the matcher to scanning,
// clears the candidate address and empties both result entries.
`default_nettype none
module function_start_pattern_matcher_unit #(
    parameter int ADDR_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_decode_ok,
    input  wire logic [ADDR_BITS-1:0] i_insn_address,
    input  wire logic [3:0]           i_mnemonic_class,
    input  wire logic [1:0]           i_first_kind,
    input  wire logic [4:0]           i_first_reg,
    input  wire logic [1:0]           i_second_kind,
    input  wire logic [4:0]           i_second_reg,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [ADDR_BITS-1:0]      o_func_addr
);
    import fspm_pkg::*;

    // Matcher state
    t_phase               r_phase, n_phase;
    logic [3:0]           r_sel, n_sel;
    logic [1:0]           r_idx, n_idx;
    logic [ADDR_BITS-1:0] r_cand, n_cand;

    // Result entries
    logic                 r_out_valid, n_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr, n_out_addr;
    logic                 r_skid_valid, n_skid_valid;
    logic [ADDR_BITS-1:0] r_skid_addr, n_skid_addr;

    logic                 accept;
    logic                 pop;
    logic                 res_valid;
    logic [ADDR_BITS-1:0] res_addr;

    // Table searches on the first element
    logic                 pre_found;
    logic [3:0]           pre_sel;
    logic                 post_found;
    logic [3:0]           post_sel;

    // Element currently followed
    logic [3:0]           pre_i;
    logic [3:0]           post_i;
    t_elem                pre_el;
    t_elem                post_el;
    logic                 pre_hit;
    logic                 post_hit;
    logic [1:0]           pre_next;
    logic [2:0]           post_next;

    assign accept  = i_valid && !o_stall;
    assign pop     = r_out_valid && !i_stall;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_func_addr = r_out_addr;

    // First pattern in each table whose opening instruction matches
    always_comb begin
        pre_found  = 1'b0;
        pre_sel    = '0;
        post_found = 1'b0;
        post_sel   = '0;
        for (int i = 0; i < N_PRE; i++) begin
            if (!pre_found && elem_match(PRE_E0[i], i_mnemonic_class, i_first_kind,
                                         i_first_reg, i_second_kind, i_second_reg)) begin
                pre_found = 1'b1;
                pre_sel   = 4'(i);
            end
        end
        for (int i = 0; i < N_POST; i++) begin
            if (!post_found && elem_match(POST_E[i][0], i_mnemonic_class, i_first_kind,
                                          i_first_reg, i_second_kind, i_second_reg)) begin
                post_found = 1'b1;
                post_sel   = 4'(i);
            end
        end
    end

    // Next element of the pattern being followed; an out-of-range select
    // falls back to the first pattern
    always_comb begin
        pre_i    = (r_sel < 4'(N_PRE)) ? r_sel : 4'd0;
        post_i   = (r_sel < 4'(N_POST)) ? r_sel : 4'd0;
        pre_el   = r_idx[0] ? PRE_E1[pre_i] : PRE_E0[pre_i];
        post_el  = POST_E[post_i][r_idx];
        pre_hit  = ({1'b0, r_idx[0]} < PRE_LEN[pre_i])
                   && elem_match(pre_el, i_mnemonic_class, i_first_kind, i_first_reg,
                                 i_second_kind, i_second_reg);
        post_hit = ({1'b0, r_idx} < POST_LEN[post_i])
                   && elem_match(post_el, i_mnemonic_class, i_first_kind, i_first_reg,
                                 i_second_kind, i_second_reg);
        pre_next  = {1'b0, r_idx[0]} + 2'd1;
        post_next = {1'b0, r_idx} + 3'd1;
    end

    // Matcher next state
    always_comb begin
        n_phase   = r_phase;
        n_sel     = r_sel;
        n_idx     = r_idx;
        n_cand    = r_cand;
        res_valid = 1'b0;
        res_addr  = r_cand;
        if (accept) begin
            if (!i_decode_ok) begin
                // drop back to scanning, keep the candidate
                n_phase = PH_SCAN;
                n_sel   = '0;
                n_idx   = '0;
            end else begin
                unique case (r_phase)
                    PH_SCAN: begin
                        n_phase = PH_SCAN;
                        n_sel   = '0;
                        n_idx   = '0;
                        if (pre_found) begin
                            n_idx = 2'd1;
                            if (PRE_LEN[pre_sel] == 2'd1) begin
                                n_phase = PH_WAIT;
                            end else begin
                                n_sel   = pre_sel;
                                n_phase = PH_PRE;
                            end
                        end
                    end
                    PH_PRE: begin
                        if (pre_hit) begin
                            n_idx = pre_next;
                            if (pre_next >= PRE_LEN[pre_i]) begin
                                n_phase = PH_WAIT;
                            end
                        end else begin
                            n_phase = PH_SCAN;
                            n_sel   = '0;
                            n_idx   = '0;
                        end
                    end
                    PH_WAIT: begin
                        n_phase = PH_SCAN;
                        n_sel   = '0;
                        n_idx   = '0;
                        if (post_found) begin
                            n_cand = i_insn_address;
                            if (POST_LEN[post_sel] == 3'd1) begin
                                // single-instruction prologue: emit now
                                res_valid = 1'b1;
                                res_addr  = i_insn_address;
                            end else begin
                                n_idx   = 2'd1;
                                n_sel   = post_sel;
                                n_phase = PH_POST;
                            end
                        end
                    end
                    PH_POST: begin
                        if (post_hit && (post_next >= POST_LEN[post_i])) begin
                            n_phase   = PH_SCAN;
                            n_sel     = '0;
                            n_idx     = '0;
                            res_valid = 1'b1;
                            res_addr  = r_cand;
                        end else if (post_hit) begin
                            n_idx = post_next[1:0];
                        end else begin
                            n_phase = PH_SCAN;
                            n_sel   = '0;
                            n_idx   = '0;
                        end
                    end
                endcase
            end
        end
    end

    // Result entries: output register with one skid entry behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_skid_valid = r_skid_valid;
        n_skid_addr  = r_skid_addr;
        if (r_skid_valid) begin
            // no new result can arrive; advance the skid entry on pop
            if (pop) begin
                n_out_addr   = r_skid_addr;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            n_out_valid = res_valid;
            if (res_valid) begin
                n_out_addr = res_addr;
            end
        end else if (res_valid) begin
            // output held by the receiver: park the result
            n_skid_valid = 1'b1;
            n_skid_addr  = res_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SCAN;
            r_sel        <= '0;
            r_idx        <= '0;
            r_cand       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_sel        <= n_sel;
            r_idx        <= n_idx;
            r_cand       <= n_cand;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr  <= n_out_addr;
        r_skid_addr <= n_skid_addr;
    end

    // The skid entry is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied with empty output register");

    // A failed decode always returns the matcher to scanning
    a_fail_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_decode_ok) |=> (r_phase == PH_SCAN && r_idx == 2'd0))
        else $error("matcher not scanning after failed decode");

    // Inside a prologue the select points at a multi-instruction entry
    a_post_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_POST) |-> (r_sel != 4'd0 && r_sel < 4'(N_POST) && r_idx != 2'd0))
        else $error("bad postpattern select in prologue phase");

    // A held result is never lost or replaced
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_addr)))
        else $error("stalled result changed or dropped");

    // A parked result moves to the output when the receiver takes one
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (!r_skid_valid && r_out_valid
                                        && r_out_addr == $past(r_skid_addr)))
        else $error("skid entry did not advance");

endmodule
`default_nettype wire
